### sv/cdq_pkg.sv
// cdq_pkg: shared constants and request codes for the counted circular deque
// no dependencies; imported by circular_deque_counted_core and tb_top
package cdq_pkg;

    localparam int DEPTH_DEFAULT  = 16;
    localparam int DATA_W         = 32;
    localparam int OP_W           = 3;
    localparam int CFG_W          = 5;
    localparam int OCC_W          = 5;
    localparam int RESET_CAPACITY = 16;

    // request codes, unlisted codes act as query
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

endpackage

### sv/circular_deque_counted_core.sv
// circular_deque_counted_core: double-ended queue held in a ring memory
// depends on cdq_pkg for widths, reset capacity and request codes
//
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+--------------------------------------
// request   | in        | i_start, o_busy         | i_op, i_value
// result    | out       | o_valid (strobe)        | o_ok, o_front_value, o_rear_value,
//           |           |                         | o_is_empty, o_is_full, o_occupancy
// config    | in        | i_cfg_we                | i_capacity
//
// a request is taken on a rising edge with i_start high and o_busy low; its
// result strobes on o_valid in the next cycle
// one request per cycle while o_busy is low: indices and count update at the accept edge, the
// push write and both slot reads go to the ring memory in that same cycle
// the read data is registered, so the result appears in the following cycle
// a read that hits the slot being written is served from the write data
// o_busy is high only during reset and until r_ready is set after it
// the result side cannot stall; every result is taken in its strobe cycle
module circular_deque_counted_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [OP_W-1:0]          i_op,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_cfg_we,
    input  logic [CFG_W-1:0]         i_capacity,
    output logic                     o_valid,
    output logic                     o_ok,
    output logic signed [DATA_W-1:0] o_front_value,
    output logic signed [DATA_W-1:0] o_rear_value,
    output logic                     o_is_empty,
    output logic                     o_is_full,
    output logic [OCC_W-1:0]         o_occupancy
);

    // index width, and count/capacity width that can hold DEPTH itself
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int CMPW      = (CW > CFG_W) ? CW : CFG_W;
    localparam int RESET_CAP = (RESET_CAPACITY > DEPTH) ? DEPTH : RESET_CAPACITY;

    // ring memory, no reset: only written slots are ever reported
    logic signed [DATA_W-1:0] mem [DEPTH];

    // control state
    logic          r_ready;
    logic [CW-1:0] r_cap;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    // result stage
    logic                     r_valid;
    logic                     r_ok;
    logic                     r_empty;
    logic                     r_full;
    logic [CW-1:0]            r_occ;
    logic                     r_fwd_front;
    logic                     r_fwd_rear;
    logic signed [DATA_W-1:0] r_wdata;
    logic signed [DATA_W-1:0] r_rd_front;
    logic signed [DATA_W-1:0] r_rd_rear;

    // request decode
    logic          accept;
    logic          n_ok;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_front_addr;
    logic [AW-1:0] rd_rear_addr;
    logic          is_full_now;
    logic          is_empty_now;

    // capacity clamp
    logic [CMPW-1:0] cap_wide;
    logic [CW-1:0]   cap_clamped;

    logic [CW+OCC_W-1:0] occ_ext;

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] idx,
                                                input logic [CW-1:0] cap);
        logic [CW-1:0] inc;
        inc = CW'(idx) + CW'(1);
        return (inc >= cap) ? '0 : AW'(inc);
    endfunction

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] idx,
                                                input logic [CW-1:0] cap);
        return (idx == '0) ? AW'(cap - CW'(1)) : idx - AW'(1);
    endfunction

    assign accept = i_start && !o_busy;
    assign o_busy = !r_ready || !i_rst_n;

    // out-of-range capacity: zero reads as one, above the depth as the depth
    always_comb begin
        cap_wide = CMPW'(i_capacity);
        if (cap_wide == '0) begin
            cap_clamped = CW'(1);
        end else if (cap_wide > CMPW'(DEPTH)) begin
            cap_clamped = CW'(DEPTH);
        end else begin
            cap_clamped = CW'(cap_wide);
        end
    end

    assign is_full_now  = (r_count >= r_cap);
    assign is_empty_now = (r_count == '0);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_ok    = 1'b1;
        wr_en   = 1'b0;
        wr_addr = r_tail;
        unique case (i_op)
            OP_PUSH_FRONT: begin
                if (is_full_now) begin
                    n_ok = 1'b0;
                end else begin
                    n_head  = slot_prev(r_head, r_cap);
                    wr_en   = 1'b1;
                    wr_addr = n_head;
                    n_count = r_count + CW'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (is_full_now) begin
                    n_ok = 1'b0;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_tail;
                    n_tail  = slot_next(r_tail, r_cap);
                    n_count = r_count + CW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (is_empty_now) begin
                    n_ok = 1'b0;
                end else begin
                    n_head  = slot_next(r_head, r_cap);
                    n_count = r_count - CW'(1);
                end
            end
            OP_POP_BACK: begin
                if (is_empty_now) begin
                    n_ok = 1'b0;
                end else begin
                    n_tail  = slot_prev(r_tail, r_cap);
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                // query and unused codes change nothing
            end
        endcase
    end

    // front is the head slot, rear is the slot just behind the tail
    assign rd_front_addr = n_head;
    assign rd_rear_addr  = slot_prev(n_tail, r_cap);

    // memory port: one write, two registered reads (old data on a collision)
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            mem[wr_addr] <= i_value;
        end
        if (accept) begin
            r_rd_front <= mem[rd_front_addr];
            r_rd_rear  <= mem[rd_rear_addr];
        end
    end

    // control state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_cap   <= CW'(RESET_CAP);
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_valid <= accept;
            if (i_cfg_we) begin
                // a capacity write empties the deque, store contents are kept
                r_cap   <= cap_clamped;
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
            end else if (accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    // result payload, captured with the request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok        <= n_ok;
            r_empty     <= (n_count == '0);
            r_full      <= (n_count == r_cap);
            r_occ       <= n_count;
            r_wdata     <= i_value;
            r_fwd_front <= wr_en && (wr_addr == rd_front_addr);
            r_fwd_rear  <= wr_en && (wr_addr == rd_rear_addr);
        end
    end

    // occupancy shows the count modulo 32
    assign occ_ext = {{OCC_W{1'b0}}, r_occ};

    assign o_valid       = r_valid;
    assign o_ok          = r_ok;
    assign o_is_empty    = r_empty;
    assign o_is_full     = r_full;
    assign o_occupancy   = occ_ext[OCC_W-1:0];
    assign o_front_value = r_empty ? '1 : (r_fwd_front ? r_wdata : r_rd_front);
    assign o_rear_value  = r_empty ? '1 : (r_fwd_rear ? r_wdata : r_rd_rear);

    // assertions

    a_strobe_follows_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid
    ) else $error("result strobe missing after an accepted request");

    a_no_spurious_strobe: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_valid
    ) else $error("result strobe without an accepted request");

    a_count_within_capacity: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap
    ) else $error("item count exceeds capacity");

    a_indices_within_capacity: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_head) < r_cap) && (CW'(r_tail) < r_cap)
    ) else $error("ring index outside the capacity");

    a_refusal_has_cause: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_is_full || o_is_empty)
    ) else $error("request refused while neither full nor empty");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for circular_deque_counted_core, a directed table then
// random request streams, checked against typed rows or a deque predictor; needs cdq_pkg and the core
module tb_top
    import cdq_pkg::*;
();

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_REQS  = 100;
    localparam int STRETCH     = 32;
    localparam int MAX_REPORTS = 10;

    // codes the core treats as a query
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic [DATA_W-1:0] NO_ITEM  = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] VAL_MAX  = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_ZERO = 32'h0000_0000;

    typedef struct {
        logic              ok;
        logic [DATA_W-1:0] front_value;
        logic [DATA_W-1:0] rear_value;
        logic              is_empty;
        logic              is_full;
        logic [OCC_W-1:0]  occupancy;
    } t_deque_status;

    typedef enum {ROW_REQUEST, ROW_CAPACITY} t_row_kind;
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    typedef struct {
        t_row_kind         kind;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        logic [CFG_W-1:0]  cap;
        bit                typed;
        t_deque_status     want;
    } t_dir_row;

    // ------------------------------------------------------------------
    // clock, dut ports
    // ------------------------------------------------------------------
    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic [OP_W-1:0]          i_op;
    logic signed [DATA_W-1:0] i_value;
    logic                     i_cfg_we;
    logic [CFG_W-1:0]         i_capacity;
    logic                     o_valid;
    logic                     o_ok;
    logic signed [DATA_W-1:0] o_front_value;
    logic signed [DATA_W-1:0] o_rear_value;
    logic                     o_is_empty;
    logic                     o_is_full;
    logic [OCC_W-1:0]         o_occupancy;

    circular_deque_counted_core #(
        .DEPTH (DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_op          (i_op),
        .i_value       (i_value),
        .i_cfg_we      (i_cfg_we),
        .i_capacity    (i_capacity),
        .o_valid       (o_valid),
        .o_ok          (o_ok),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_occupancy   (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // deque predictor: own copy of ring, indices, count and capacity
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] dq_ring [DEPTH];
    int unsigned       dq_head  = 0;
    int unsigned       dq_tail  = 0;
    int unsigned       dq_count = 0;
    int unsigned       dq_cap   = RESET_CAPACITY;

    // wrap within the slots in use, not the built depth
    function automatic int unsigned slot_up(input int unsigned i);
        return (i + 1 >= dq_cap) ? 0 : i + 1;
    endfunction

    function automatic int unsigned slot_down(input int unsigned i);
        return (i == 0) ? dq_cap - 1 : i - 1;
    endfunction

    // capacity write: clamp to 1..DEPTH, deque emptied, ring contents kept
    function automatic void capacity_update(input logic [CFG_W-1:0] v);
        if (v == 0)
            dq_cap = 1;
        else if (v > DEPTH)
            dq_cap = DEPTH;
        else
            dq_cap = v;
        dq_head  = 0;
        dq_tail  = 0;
        dq_count = 0;
    endfunction

    function automatic t_deque_status deque_apply(input logic [OP_W-1:0] op,
                                                  input logic [DATA_W-1:0] val);
        t_deque_status st;
        st.ok = 1'b1;
        case (op)
            OP_PUSH_FRONT: begin
                if (dq_count >= dq_cap) begin
                    st.ok = 1'b0;
                end else begin
                    dq_head = slot_down(dq_head);
                    dq_ring[dq_head] = val;
                    dq_count++;
                end
            end
            OP_PUSH_BACK: begin
                if (dq_count >= dq_cap) begin
                    st.ok = 1'b0;
                end else begin
                    dq_ring[dq_tail] = val;
                    dq_tail = slot_up(dq_tail);
                    dq_count++;
                end
            end
            OP_POP_FRONT: begin
                if (dq_count == 0) begin
                    st.ok = 1'b0;
                end else begin
                    dq_head = slot_up(dq_head);
                    dq_count--;
                end
            end
            OP_POP_BACK: begin
                if (dq_count == 0) begin
                    st.ok = 1'b0;
                end else begin
                    dq_tail = slot_down(dq_tail);
                    dq_count--;
                end
            end
            default: begin
                // query and spare codes leave everything alone
            end
        endcase
        if (dq_count == 0) begin
            st.front_value = NO_ITEM;
            st.rear_value  = NO_ITEM;
        end else begin
            st.front_value = dq_ring[dq_head];
            st.rear_value  = dq_ring[slot_down(dq_tail)];
        end
        st.is_empty  = (dq_count == 0);
        st.is_full   = (dq_count == dq_cap);
        st.occupancy = OCC_W'(dq_count);
        return st;
    endfunction

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    t_dir_row dir_table[$];

    function automatic void row_req(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] v);
        t_dir_row r;
        r.kind  = ROW_REQUEST;
        r.op    = op;
        r.value = v;
        r.cap   = '0;
        r.typed = 1'b0;
        dir_table.push_back(r);
    endfunction

    function automatic void row_chk(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] v,
                                    input logic ok, input logic [DATA_W-1:0] fv,
                                    input logic [DATA_W-1:0] rv, input logic e,
                                    input logic f, input logic [OCC_W-1:0] occ);
        t_dir_row r;
        r.kind             = ROW_REQUEST;
        r.op               = op;
        r.value            = v;
        r.cap              = '0;
        r.typed            = 1'b1;
        r.want.ok          = ok;
        r.want.front_value = fv;
        r.want.rear_value  = rv;
        r.want.is_empty    = e;
        r.want.is_full     = f;
        r.want.occupancy   = occ;
        dir_table.push_back(r);
    endfunction

    function automatic void row_cap(input logic [CFG_W-1:0] c);
        t_dir_row r;
        r.kind  = ROW_CAPACITY;
        r.op    = OP_QUERY;
        r.value = '0;
        r.cap   = c;
        r.typed = 1'b0;
        dir_table.push_back(r);
    endfunction

    function automatic void build_dir_table();
        // refused pops and queries on the empty deque right after reset
        row_chk(OP_POP_FRONT, VAL_ZERO,     1'b0, NO_ITEM, NO_ITEM, 1'b1, 1'b0, 5'd0);
        row_chk(OP_POP_BACK,  32'h5a5a5a5a, 1'b0, NO_ITEM, NO_ITEM, 1'b1, 1'b0, 5'd0);
        row_chk(OP_QUERY,     VAL_MAX,      1'b1, NO_ITEM, NO_ITEM, 1'b1, 1'b0, 5'd0);
        row_chk(OP_SPARE_5,   VAL_MIN,      1'b1, NO_ITEM, NO_ITEM, 1'b1, 1'b0, 5'd0);
        row_chk(OP_SPARE_6,   NO_ITEM,      1'b1, NO_ITEM, NO_ITEM, 1'b1, 1'b0, 5'd0);
        row_chk(OP_SPARE_7,   VAL_ZERO,     1'b1, NO_ITEM, NO_ITEM, 1'b1, 1'b0, 5'd0);
        // value extremes at both ends
        row_chk(OP_PUSH_BACK,  VAL_MAX,     1'b1, VAL_MAX, VAL_MAX, 1'b0, 1'b0, 5'd1);
        row_chk(OP_PUSH_FRONT, VAL_MIN,     1'b1, VAL_MIN, VAL_MAX, 1'b0, 1'b0, 5'd2);
        row_req(OP_PUSH_FRONT, NO_ITEM);
        row_req(OP_PUSH_BACK,  VAL_ZERO);
        row_req(OP_QUERY,      32'hdeadbeef);
        row_req(OP_POP_BACK,   VAL_ZERO);
        row_req(OP_POP_FRONT,  VAL_ZERO);
        row_req(OP_POP_BACK,   VAL_ZERO);
        row_req(OP_POP_FRONT,  VAL_ZERO);
        row_chk(OP_POP_FRONT,  VAL_ZERO,    1'b0, NO_ITEM, NO_ITEM, 1'b1, 1'b0, 5'd0);
        // capacity 0 is taken as 1: one push fills it, further pushes refused
        row_cap(5'd0);
        row_chk(OP_PUSH_BACK,  32'h12345678, 1'b1, 32'h12345678, 32'h12345678,
                1'b0, 1'b1, 5'd1);
        row_chk(OP_PUSH_FRONT, 32'h55555555, 1'b0, 32'h12345678, 32'h12345678,
                1'b0, 1'b1, 5'd1);
        row_chk(OP_PUSH_BACK,  32'haaaaaaaa, 1'b0, 32'h12345678, 32'h12345678,
                1'b0, 1'b1, 5'd1);
        row_chk(OP_POP_FRONT,  VAL_ZERO,     1'b1, NO_ITEM, NO_ITEM, 1'b1, 1'b0, 5'd0);
        row_req(OP_PUSH_FRONT, 32'haaaaaaaa);
        // capacity above depth is clamped, and the write empties a non-empty deque
        row_cap(5'd31);
        row_chk(OP_QUERY,      VAL_ZERO,     1'b1, NO_ITEM, NO_ITEM, 1'b1, 1'b0, 5'd0);
        row_req(OP_PUSH_BACK,  32'h0f0f0f0f);
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    t_deque_status pending_status[$];
    bit            no_idle     = 1'b0;
    int            error_count = 0;
    int            result_seen = 0;
    int            cycle_count = 0;

    // one request: random idle gap, then hold start until the core takes it
    task automatic issue_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                                 input bit typed, input t_deque_status want);
        int            gap;
        t_deque_status pred;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_op    <= op;
        i_value <= val;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        // taken at this edge; predictor always advances, typed rows override
        pred = deque_apply(op, val);
        pending_status.push_back(typed ? want : pred);
    endtask

    // capacity only changes with nothing in flight
    task automatic write_capacity(input logic [CFG_W-1:0] v);
        i_start <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_capacity <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        capacity_update(v);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input t_mix mix);
        int r;
        int t_pf;
        int t_pb;
        int t_qf;
        int t_qb;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                t_pf = 40; t_pb = 75; t_qf = 85; t_qb = 92;
            end
            MIX_DRAIN: begin
                t_pf = 10; t_pb = 20; t_qf = 55; t_qb = 90;
            end
            default: begin
                t_pf = 22; t_pb = 44; t_qf = 66; t_qb = 88;
            end
        endcase
        if (r < t_pf)
            return OP_PUSH_FRONT;
        if (r < t_pb)
            return OP_PUSH_BACK;
        if (r < t_qf)
            return OP_POP_FRONT;
        if (r < t_qb)
            return OP_POP_BACK;
        case ($urandom_range(0, 3))
            0:       return OP_QUERY;
            1:       return OP_SPARE_5;
            2:       return OP_SPARE_6;
            default: return OP_SPARE_7;
        endcase
    endfunction

    // mostly full-range random, now and then an extreme
    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 15) != 0)
            return $urandom();
        case ($urandom_range(0, 3))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return VAL_ZERO;
            default: return NO_ITEM;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checker: every strobe matches the oldest pending status
    // ------------------------------------------------------------------
    t_deque_status head_status;

    task automatic check_field(input string field, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("result %0d %s mismatch: expected %h got %h",
                         result_seen, field, want, got);
        end
    endtask

    // sampled at the edge that ends the strobe cycle, pre-update values
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_status.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("result %0d arrived with no request pending", result_seen);
            end else begin
                head_status = pending_status.pop_front();
                check_field("ok",          o_ok,          head_status.ok);
                check_field("front_value", o_front_value, head_status.front_value);
                check_field("rear_value",  o_rear_value,  head_status.rear_value);
                check_field("is_empty",    o_is_empty,    head_status.is_empty);
                check_field("is_full",     o_is_full,     head_status.is_full);
                check_field("occupancy",   o_occupancy,   head_status.occupancy);
            end
            result_seen++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_deque_status    no_status;
        t_mix             mix;
        logic [CFG_W-1:0] cap_plan [8];

        // all inputs known from time zero, reset held low
        i_rst_n    <= 1'b0;
        i_start    <= 1'b0;
        i_op       <= OP_QUERY;
        i_value    <= '0;
        i_cfg_we   <= 1'b0;
        i_capacity <= '0;
        no_status.ok          = 1'b0;
        no_status.front_value = '0;
        no_status.rear_value  = '0;
        no_status.is_empty    = 1'b0;
        no_status.is_full     = 1'b0;
        no_status.occupancy   = '0;
        mix = MIX_EVEN;
        // capacity schedule for the random part: extremes, clamps and a few middles
        cap_plan = '{5'd31, 5'd1, 5'd2, 5'd7, 5'd16, 5'd0, 5'd20, 5'd12};
        build_dir_table();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows, with typed expectations where obvious
        foreach (dir_table[k]) begin
            if (dir_table[k].kind == ROW_CAPACITY)
                write_capacity(dir_table[k].cap);
            else
                issue_request(dir_table[k].op, dir_table[k].value,
                              dir_table[k].typed, dir_table[k].want);
        end

        // random phases: stretches that fill, drain or churn the deque, so
        // full refusals, empty refusals and wrap at each phase's capacity are reached
        for (int p = 0; p < 8; p++) begin
            write_capacity((p == 7) ? CFG_W'($urandom_range(0, 31)) : cap_plan[p]);
            for (int n = 0; n < PHASE_REQS; n++) begin
                if (n % STRETCH == 0) begin
                    mix     = t_mix'($urandom_range(0, 2));
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                issue_request(pick_op(mix), pick_value(), 1'b0, no_status);
            end
        end

        // drain: nothing left in flight, then a short tail for stray strobes
        i_start <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (error_count == 0 && pending_status.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
